// ===== hw/rtl/grr_pkg.sv =====
// Shared constants, codes and control types for the glyph row renderer.
`default_nettype none

package grr_pkg;

    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_WIDTH = 8;
    localparam int GLYPH_COUNT = 256;

    localparam int ROW_W       = $clog2(GLYPH_ROWS);
    localparam int CODE_W      = $clog2(GLYPH_COUNT);
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int X_W       = 12;
    localparam int Y_W       = 12;
    localparam int CODE_IN_W = 8;
    localparam int LROW_W    = 4;
    localparam int COLOR_W   = 24;
    localparam int IDX_W     = 26;
    localparam int PITCH_W   = 14;
    localparam int LANE_W    = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_ORDER      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LINE_PIXELS = 1'd1;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 14'd1024;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic capture;
        logic base;
        logic advance;
    } t_grr_cmd;

    typedef struct packed {
        logic last_row;
        logic out_free;
    } t_grr_status;

endpackage

`default_nettype wire

// ===== hw/rtl/grr_in_if.sv =====
// Input channel: valid/ready handshake with one request word.
`default_nettype none

interface grr_in_if;
    import grr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [X_W-1:0]       x;
    logic [Y_W-1:0]       y;
    logic [CODE_IN_W-1:0] glyph_code;
    logic [LROW_W-1:0]    load_row;
    logic [GLYPH_WIDTH-1:0] load_bits;
    logic [COLOR_W-1:0]   color;

    modport source (
        output valid, req_type, x, y, glyph_code, load_row, load_bits, color,
        input  ready
    );

    modport sink (
        input  valid, req_type, x, y, glyph_code, load_row, load_bits, color,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/grr_out_if.sv =====
// Output channel: valid/ready handshake with one row write word.
`default_nettype none

interface grr_out_if;
    import grr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [IDX_W-1:0]       pixel_index;
    logic [GLYPH_WIDTH-1:0] pixel_mask;
    logic [COLOR_W-1:0]     pixel_word;
    logic                   last;

    modport source (
        output valid, pixel_index, pixel_mask, pixel_word, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_index, pixel_mask, pixel_word, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/grr_ctrl.sv =====
// Controller state machine: accepts requests and sequences the glyph rows.
`default_nettype none

module grr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_req_type,
    output logic                   o_in_ready,
    input  wire grr_pkg::t_grr_status i_status,
    output grr_pkg::t_grr_cmd      o_cmd
);
    import grr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BASE = 3'b010,
        ST_ROWS = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load_wr = accept && (i_req_type == REQ_LOAD);
        o_cmd.capture = accept && (i_req_type == REQ_DRAW);
        o_cmd.base    = (r_state == ST_BASE);
        o_cmd.advance = (r_state == ST_ROWS) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                n_state = ST_ROWS;
            end
            ST_ROWS: begin
                if (o_cmd.advance && i_status.last_row) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/grr_datapath.sv =====
// Datapath: configuration, font memory, row address stepping and output register.
`default_nettype none

module grr_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [grr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic [grr_pkg::X_W-1:0]            i_x,
    input  wire logic [grr_pkg::Y_W-1:0]            i_y,
    input  wire logic [grr_pkg::CODE_IN_W-1:0]      i_glyph_code,
    input  wire logic [grr_pkg::LROW_W-1:0]         i_load_row,
    input  wire logic [grr_pkg::GLYPH_WIDTH-1:0]    i_load_bits,
    input  wire logic [grr_pkg::COLOR_W-1:0]        i_color,
    input  wire grr_pkg::t_grr_cmd                  i_cmd,
    output grr_pkg::t_grr_status                    o_status,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [grr_pkg::IDX_W-1:0]               o_pixel_index,
    output logic [grr_pkg::GLYPH_WIDTH-1:0]         o_pixel_mask,
    output logic [grr_pkg::COLOR_W-1:0]             o_pixel_word,
    output logic                                    o_last
);
    import grr_pkg::*;

    localparam int CHK_W = LROW_W + ROW_W + 1;

    logic                   r_pixel_order;
    logic [PITCH_W-1:0]     r_pitch;

    logic [GLYPH_WIDTH-1:0] r_font_mem [STORE_DEPTH];
    logic [GLYPH_WIDTH-1:0] r_rd_data;

    logic [CODE_W-1:0]      r_code;
    logic [X_W-1:0]         r_x;
    logic [Y_W-1:0]         r_y;
    logic [COLOR_W-1:0]     r_word;
    logic [IDX_W-1:0]       r_idx;
    logic [ROW_W-1:0]       r_row;

    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_index;
    logic [GLYPH_WIDTH-1:0] r_out_mask;
    logic [COLOR_W-1:0]     r_out_word;
    logic                   r_out_last;

    logic [CODE_W-1:0]      code_wrap;
    logic [CODE_IN_W:0]     code_ext;
    logic                   load_row_ok;
    logic [STORE_AW-1:0]    wr_addr;
    logic [STORE_AW-1:0]    rd_addr;
    logic [ROW_W-1:0]       rd_row;
    logic                   rd_en;
    logic                   last_row;
    logic [Y_W+PITCH_W-1:0] base_prod;
    logic [COLOR_W-1:0]     packed_color;
    logic [GLYPH_WIDTH-1:0] rev_mask;

    // wrap the glyph code into the font; a code is below twice the glyph count
    always_comb begin
        code_ext = {1'b0, i_glyph_code};
        if (code_ext >= (CODE_IN_W+1)'(GLYPH_COUNT)) begin
            code_wrap = CODE_W'(code_ext - (CODE_IN_W+1)'(GLYPH_COUNT));
        end else begin
            code_wrap = CODE_W'(code_ext);
        end
    end

    assign load_row_ok = CHK_W'(i_load_row) < CHK_W'(GLYPH_ROWS);
    assign wr_addr     = STORE_AW'(code_wrap) * STORE_AW'(GLYPH_ROWS)
                       + STORE_AW'(i_load_row);

    assign last_row = (r_row == ROW_W'(GLYPH_ROWS - 1));
    assign rd_en    = i_cmd.base || i_cmd.advance;
    assign rd_row   = (i_cmd.base || last_row) ? '0 : ROW_W'(r_row + 1'b1);
    assign rd_addr  = STORE_AW'(r_code) * STORE_AW'(GLYPH_ROWS) + STORE_AW'(rd_row);

    assign base_prod = r_y * r_pitch;

    always_comb begin
        if (r_pixel_order) begin
            packed_color = i_color;
        end else begin
            packed_color = {i_color[LANE_W-1:0], i_color[2*LANE_W-1:LANE_W],
                            i_color[3*LANE_W-1:2*LANE_W]};
        end
    end

    always_comb begin
        for (int j = 0; j < GLYPH_WIDTH; j++) begin
            rev_mask[j] = r_rd_data[GLYPH_WIDTH-1-j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_order <= 1'b0;
            r_pitch       <= PITCH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PIXEL_ORDER:      r_pixel_order <= i_cfg_wdata[0];
                CFG_SCAN_LINE_PIXELS: r_pitch       <= i_cfg_wdata[PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && load_row_ok) begin
            r_font_mem[wr_addr] <= i_load_bits;
        end
        if (rd_en) begin
            r_rd_data <= r_font_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code <= code_wrap;
            r_x    <= i_x;
            r_y    <= i_y;
            r_word <= packed_color;
        end
        if (i_cmd.base) begin
            r_idx <= IDX_W'(base_prod) + IDX_W'(r_x);
            r_row <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IDX_W'(r_pitch);
            r_row <= ROW_W'(r_row + 1'b1);
        end
        if (i_cmd.advance) begin
            r_out_index <= r_idx;
            r_out_mask  <= rev_mask;
            r_out_word  <= r_word;
            r_out_last  <= last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.last_row = last_row;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_index;
    assign o_pixel_mask  = r_out_mask;
    assign o_pixel_word  = r_out_word;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/glyph_row_renderer_core.sv =====
// Top level of the glyph row renderer: controller, datapath and channel ports.
// A load word is written to the font memory on acceptance; the next word can be accepted on the following cycle.
// A draw word passes the base state, which reads row 0 and forms the base index, then the row
// state: one row per cycle from the font memory read port while the output is free, 16 rows.
// Reset clears the controller, the output valid and the configuration registers;
// the font memory is not cleared and must be loaded before a glyph is drawn.
`default_nettype none

module glyph_row_renderer_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [grr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    grr_in_if.sink                              i_in,
    grr_out_if.source                           o_out
);
    import grr_pkg::*;

    t_grr_cmd    cmd;
    t_grr_status status;
    logic        in_ready;

    grr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    grr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_x           (i_in.x),
        .i_y           (i_in.y),
        .i_glyph_code  (i_in.glyph_code),
        .i_load_row    (i_in.load_row),
        .i_load_bits   (i_in.load_bits),
        .i_color       (i_in.color),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_pixel_index (o_out.pixel_index),
        .o_pixel_mask  (o_out.pixel_mask),
        .o_pixel_word  (o_out.pixel_word),
        .o_last        (o_out.last)
    );

    assign i_in.ready = in_ready;

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.req_type == REQ_DRAW)
            |=> !i_in.ready ##1 !i_in.ready)
        else $error("draw word did not hold off input");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.req_type == REQ_LOAD) |=> i_in.ready)
        else $error("load word stalled input");

    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last |-> !i_in.ready)
        else $error("input accepted before last row was produced");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.advance && status.last_row |=> o_out.valid && o_out.last)
        else $error("final row not flagged last");

endmodule

`default_nettype wire

// ===== tb/glyph_row_renderer_core_tb.sv =====
// Self-checking testbench for glyph_row_renderer_core: font loads, glyph draws, row checks.
`timescale 1ns / 100ps

module glyph_row_renderer_core_tb;
    import grr_pkg::*;

    typedef struct {
        logic                   req_type;
        logic [X_W-1:0]         x;
        logic [Y_W-1:0]         y;
        logic [CODE_IN_W-1:0]   glyph_code;
        logic [LROW_W-1:0]      load_row;
        logic [GLYPH_WIDTH-1:0] load_bits;
        logic [COLOR_W-1:0]     color;
    } t_glyph_req;

    typedef struct {
        logic [IDX_W-1:0]       pixel_index;
        logic [GLYPH_WIDTH-1:0] pixel_mask;
        logic [COLOR_W-1:0]     pixel_word;
        logic                   last;
    } t_row_write;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    grr_in_if  req_ch ();
    grr_out_if row_ch ();

    glyph_row_renderer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_ch),
        .o_out       (row_ch)
    );

    always #4 i_clk = ~i_clk;

    t_glyph_req pend_q [$];
    t_row_write row_q [$];
    t_glyph_req next_req;

    logic [GLYPH_WIDTH-1:0] font_rows [STORE_DEPTH];
    logic                   model_order;
    logic [PITCH_W-1:0]     model_pitch;

    logic [GLYPH_ROWS-1:0] rows_written [GLYPH_COUNT];
    bit                    glyph_ready [GLYPH_COUNT];
    int                    ready_codes [$];

    int  idle_pct;
    int  stall_pct;
    bit  req_taken;
    int  n_pushed;
    int  n_taken;
    int  n_loads;
    int  n_draws;
    int  rows_checked;
    int  errors;

    function automatic void render_glyph_rows(t_glyph_req r);
        int unsigned code;
        logic [31:0] base;
        logic [GLYPH_WIDTH-1:0] bits;
        t_row_write w;
        code = r.glyph_code % GLYPH_COUNT;
        if (r.req_type == REQ_LOAD) begin
            if (r.load_row < GLYPH_ROWS)
                font_rows[code * GLYPH_ROWS + r.load_row] = r.load_bits;
            return;
        end
        for (int row = 0; row < GLYPH_ROWS; row++) begin
            bits = font_rows[code * GLYPH_ROWS + row];
            base = (32'(r.y) + 32'(row)) * 32'(model_pitch) + 32'(r.x);
            w.pixel_index = base[IDX_W-1:0];
            for (int j = 0; j < GLYPH_WIDTH; j++)
                w.pixel_mask[j] = bits[GLYPH_WIDTH-1-j];
            if (model_order)
                w.pixel_word = r.color;
            else
                w.pixel_word = {r.color[7:0], r.color[15:8], r.color[23:16]};
            w.last = (row == GLYPH_ROWS - 1);
            row_q.push_back(w);
        end
    endfunction

    function automatic void push_load(int code, int row, logic [GLYPH_WIDTH-1:0] bits);
        t_glyph_req r;
        r.req_type   = REQ_LOAD;
        r.x          = X_W'($urandom);
        r.y          = Y_W'($urandom);
        r.glyph_code = CODE_IN_W'(code);
        r.load_row   = LROW_W'(row);
        r.load_bits  = bits;
        r.color      = COLOR_W'($urandom);
        pend_q.push_back(r);
        n_pushed++;
        n_loads++;
        rows_written[code][row] = 1'b1;
        if (&rows_written[code] && !glyph_ready[code]) begin
            glyph_ready[code] = 1'b1;
            ready_codes.push_back(code);
        end
    endfunction

    function automatic void push_draw(int px, int py, int code, logic [COLOR_W-1:0] color);
        t_glyph_req r;
        r.req_type   = REQ_DRAW;
        r.x          = X_W'(px);
        r.y          = Y_W'(py);
        r.glyph_code = CODE_IN_W'(code);
        r.load_row   = LROW_W'($urandom);
        r.load_bits  = GLYPH_WIDTH'($urandom);
        r.color      = color;
        pend_q.push_back(r);
        n_pushed++;
        n_draws++;
    endfunction

    function automatic int pick_coord();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 4095 : 0;
        return $urandom_range(4095);
    endfunction

    function automatic logic [GLYPH_WIDTH-1:0] pick_bits();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            default: return GLYPH_WIDTH'($urandom);
        endcase
    endfunction

    function automatic void add_random(int count);
        int added;
        int code;
        logic [COLOR_W-1:0] color;
        added = 0;
        while (added < count) begin
            if (ready_codes.size() < 2 || $urandom_range(15) == 0) begin
                code = $urandom_range(GLYPH_COUNT - 1);
                for (int row = 0; row < GLYPH_ROWS; row++)
                    push_load(code, row, pick_bits());
                added += GLYPH_ROWS;
            end else if ($urandom_range(5) == 0) begin
                push_load($urandom_range(GLYPH_COUNT - 1), $urandom_range(GLYPH_ROWS - 1),
                          pick_bits());
                added++;
            end else begin
                code = ready_codes[$urandom_range(ready_codes.size() - 1)];
                case ($urandom_range(7))
                    0: color = '0;
                    1: color = '1;
                    default: color = COLOR_W'($urandom);
                endcase
                push_draw(pick_coord(), pick_coord(), code, color);
                added++;
            end
        end
    endfunction

    task automatic settle();
        while (pend_q.size() != 0 || n_taken != n_pushed)
            @(negedge i_clk);
        while (row_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        if (idx == CFG_PIXEL_ORDER)
            model_order = value[0];
        else
            model_pitch = value[PITCH_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Driver: change inputs at the falling edge.
    always @(negedge i_clk) begin
        row_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_req = pend_q.pop_front();
                req_ch.req_type   <= next_req.req_type;
                req_ch.x          <= next_req.x;
                req_ch.y          <= next_req.y;
                req_ch.glyph_code <= next_req.glyph_code;
                req_ch.load_row   <= next_req.load_row;
                req_ch.load_bits  <= next_req.load_bits;
                req_ch.color      <= next_req.color;
                req_ch.valid      <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: sample both channels at the rising edge.
    always @(posedge i_clk) begin
        t_glyph_req r;
        t_row_write exp_row;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                r.req_type   = req_ch.req_type;
                r.x          = req_ch.x;
                r.y          = req_ch.y;
                r.glyph_code = req_ch.glyph_code;
                r.load_row   = req_ch.load_row;
                r.load_bits  = req_ch.load_bits;
                r.color      = req_ch.color;
                render_glyph_rows(r);
                req_taken = 1'b1;
                n_taken++;
            end
            if (row_ch.valid && row_ch.ready) begin
                if (row_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected row word: idx %h mask %h word %h last %b",
                                 row_ch.pixel_index, row_ch.pixel_mask,
                                 row_ch.pixel_word, row_ch.last);
                end else begin
                    exp_row = row_q.pop_front();
                    rows_checked++;
                    if (row_ch.pixel_index !== exp_row.pixel_index
                        || row_ch.pixel_mask !== exp_row.pixel_mask
                        || row_ch.pixel_word !== exp_row.pixel_word
                        || row_ch.last !== exp_row.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("row mismatch: exp idx %h mask %h word %h last %b, %s",
                                     exp_row.pixel_index, exp_row.pixel_mask,
                                     exp_row.pixel_word, exp_row.last,
                                     $sformatf("got idx %h mask %h word %h last %b",
                                               row_ch.pixel_index, row_ch.pixel_mask,
                                               row_ch.pixel_word, row_ch.last));
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [GLYPH_WIDTH-1:0] dir_bits [10];
        int idle_set [4];
        int stall_set [4];
        logic order_set [4];
        logic [CFG_DATA_W-1:0] pitch_set [4];

        dir_bits  = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h55, 8'haa, 8'h0f, 8'hf0, 8'h3c, 8'hc3};
        idle_set  = '{0, 57, 0, 17};
        stall_set = '{0, 0, 57, 17};
        order_set = '{1'b1, 1'b0, 1'b1, 1'b0};
        pitch_set = '{14'd16383, 14'd1, 14'd8192, 14'd0};

        for (int g = 0; g < GLYPH_COUNT; g++) begin
            rows_written[g] = '0;
            glyph_ready[g]  = 1'b0;
        end
        model_order  = 1'b0;
        model_pitch  = PITCH_RESET;
        idle_pct     = 0;
        stall_pct    = 0;
        req_taken    = 1'b0;
        n_pushed     = 0;
        n_taken      = 0;
        n_loads      = 0;
        n_draws      = 0;
        rows_checked = 0;
        errors       = 0;

        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = CFG_PIXEL_ORDER;
        i_cfg_wdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LOAD;
        req_ch.x          = '0;
        req_ch.y          = '0;
        req_ch.glyph_code = '0;
        req_ch.load_row   = '0;
        req_ch.load_bits  = '0;
        req_ch.color      = '0;
        row_ch.ready      = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill one glyph with edge patterns, then draw it at two corners and at an inner point.
        for (int row = 0; row < GLYPH_ROWS; row++)
            push_load(GLYPH_COUNT - 1, row, (row < 10) ? dir_bits[row] : pick_bits());
        push_draw(0, 0, GLYPH_COUNT - 1, 24'h000000);
        push_draw(4095, 4095, GLYPH_COUNT - 1, 24'hffffff);
        push_draw(12'h555, 12'haaa, GLYPH_COUNT - 1, 24'h123456);
        settle();

        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_PIXEL_ORDER, CFG_DATA_W'(order_set[p]));
            write_reg(CFG_SCAN_LINE_PIXELS, pitch_set[p]);
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            add_random(78);
            settle();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (40) @(negedge i_clk);
        if (row_q.size() != 0) begin
            errors++;
            $display("%0d row words never arrived", row_q.size());
        end

        $display("covered %0d font loads and %0d glyph draws, %0d row words checked",
                 n_loads, n_draws, rows_checked);
        $display("both pixel orders, pitches 0/1/1024/8192/16383, four idle/stall mixes");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== glyph_row_renderer_core.f =====
hw/rtl/grr_pkg.sv
hw/rtl/grr_in_if.sv
hw/rtl/grr_out_if.sv
hw/rtl/grr_ctrl.sv
hw/rtl/grr_datapath.sv
hw/rtl/glyph_row_renderer_core.sv
tb/glyph_row_renderer_core_tb.sv
